// ===== rtl/qwt_pkg.sv =====
// Shared types and constants for the quoted word tokenizer.
// No dependencies; imported by every module of the block.
package qwt_pkg;

    localparam int SEPARATOR_SLOTS = 4;
    localparam int SEP_REGS        = 4;
    localparam int SEP_LIMIT       = (SEPARATOR_SLOTS < SEP_REGS) ? SEPARATOR_SLOTS : SEP_REGS;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_WORD = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_TERM = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [2:0] CFG_SEP_A     = 3'd0;
    localparam logic [2:0] CFG_SEP_B     = 3'd1;
    localparam logic [2:0] CFG_SEP_C     = 3'd2;
    localparam logic [2:0] CFG_SEP_D     = 3'd3;
    localparam logic [2:0] CFG_SEP_COUNT = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] kind;
    } t_out_item;

    typedef struct packed {
        logic      push;
        t_out_item item;
    } t_q_push;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== rtl/quoted_word_tokenizer_top.sv =====
// Quoted word tokenizer: one character or end-of-stream mark per input transaction,
// one word character or word end per output transaction. A transaction is taken every
// cycle while the four-entry result queue has room; a result passes through the queue
// into the output register, and the sustained rate is one character per cycle while the
// queue has room, set by the state update in the front end. Separator registers are
// written by the user only while the block is idle; the block does not enforce this.
// Top level; instantiates qwt_front, qwt_queue and qwt_back, uses qwt_pkg.
module quoted_word_tokenizer_top
    import qwt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    t_q_push   q_push;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    t_out_item q_head;

    qwt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_q_push    (q_push)
    );

    qwt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    qwt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/qwt_front.sv =====
// Front end: accepts characters, holds tokenizer state and separator config,
// classifies each character and pushes result transactions. Uses qwt_pkg.
module qwt_front
    import qwt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_q_full,
    output t_q_push    o_q_push
);

    logic [7:0] r_sep [SEP_REGS];
    logic [2:0] r_sep_count;
    logic [1:0] r_phase, n_phase;
    logic       r_quoted, n_quoted;

    logic [3:0] lim;
    logic       is_sep;
    logic       blank;
    logic [1:0] ph;
    logic       emit;
    logic       accept;
    t_out_item  res;
    logic [7:0] c;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign c          = i_in_item.in_char;
    assign blank      = is_blank(c);

    assign lim = ({1'b0, r_sep_count} > 4'(SEP_LIMIT)) ? 4'(SEP_LIMIT) : {1'b0, r_sep_count};

    always_comb begin
        is_sep = 1'b0;
        for (int i = 0; i < SEP_REGS; i++) begin
            if ((4'(i) < lim) && (r_sep[i] == c)) begin
                is_sep = 1'b1;
            end
        end
    end

    // phase code 3 behaves as skipping
    assign ph = (r_phase == PH_WORD || r_phase == PH_ESC) ? r_phase : PH_SKIP;

    always_comb begin
        n_phase      = ph;
        n_quoted     = r_quoted;
        emit         = 1'b0;
        res.out_char = c;
        res.kind     = KIND_CHAR;
        priority if (i_in_item.end_of_stream) begin
            n_phase      = PH_SKIP;
            n_quoted     = 1'b0;
            emit         = (ph != PH_SKIP);
            res.out_char = 8'd0;
            res.kind     = KIND_END;
        end else if (ph == PH_ESC) begin
            n_phase = PH_WORD;
            emit    = 1'b1;
        end else if (ph == PH_SKIP && blank) begin
            emit = 1'b0;
        end else begin
            n_phase = PH_WORD;
            priority if (c == CH_BACKSLASH) begin
                n_phase = PH_ESC;
            end else if (c == CH_QUOTE) begin
                n_quoted = !r_quoted;
            end else if (!r_quoted && (blank || is_sep)) begin
                n_phase  = PH_SKIP;
                emit     = 1'b1;
                res.kind = KIND_TERM;
            end else begin
                emit = 1'b1;
            end
        end
    end

    assign o_q_push.push = accept && emit;
    assign o_q_push.item = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_quoted    <= 1'b0;
            r_sep_count <= 3'd0;
            for (int i = 0; i < SEP_REGS; i++) begin
                r_sep[i] <= 8'd0;
            end
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_quoted <= n_quoted;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SEP_A:     r_sep[0]    <= i_cfg_wdata;
                    CFG_SEP_B:     r_sep[1]    <= i_cfg_wdata;
                    CFG_SEP_C:     r_sep[2]    <= i_cfg_wdata;
                    CFG_SEP_D:     r_sep[3]    <= i_cfg_wdata;
                    CFG_SEP_COUNT: r_sep_count <= i_cfg_wdata[2:0];
                    default:       r_sep_count <= r_sep_count;
                endcase
            end
        end
    end

endmodule

// ===== rtl/qwt_queue.sv =====
// Short result queue between front and back ends.
// Register-based FIFO of t_out_item entries; uses qwt_pkg.
module qwt_queue
    import qwt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_push   i_push,
    output logic      o_full,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_head
);

    t_out_item      r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;
    logic           do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push.push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/qwt_back.sv =====
// Back end: drains the result queue into the registered output channel.
// Uses qwt_pkg.
module qwt_back
    import qwt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_out_item i_q_head,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;
    logic      load;

    assign load        = !i_q_empty && (!r_valid || i_out_ready);
    assign o_q_pop     = load;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.kind     <= i_q_head.kind;
            // end-of-stream results carry no character
            r_item.out_char <= (i_q_head.kind == KIND_END) ? 8'd0 : i_q_head.out_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule
